[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/fdhrl_pkg.sv]
// Shared constants, types and gain helpers for the half-rate feedback delay.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdhrl_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int STEP_W           = 5;
   localparam int GAIN_W           = 11;
   localparam int CSR_IDX_W        = 2;

   localparam int STEP_SAMPLES_DEF = 220;
   localparam int STEP_COUNT_DEF   = 19;

   localparam logic [GAIN_W-1:0] GAIN_STEP  = 11'd60;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 11'd1024;
   localparam int                MIX_SHIFT  = 10;

   localparam logic [STEP_W-1:0] DELAY_STEP_RST    = 5'd18;
   localparam logic [STEP_W-1:0] FEEDBACK_STEP_RST = 5'd9;
   localparam logic [STEP_W-1:0] BALANCE_STEP_RST  = 5'd9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY    = 2'd0,
      CSR_FEEDBACK = 2'd1,
      CSR_BALANCE  = 2'd2
   } csr_index_type;

   // 60 per step; steps are at most 31 so the product stays below 2048
   function automatic logic [GAIN_W-1:0] step_gain(input logic [STEP_W-1:0] step);
      logic [GAIN_W-1:0] prod;
      prod = GAIN_W'(step) * GAIN_STEP;
      return prod;
   endfunction

endpackage

`default_nettype wire

[rtl/feedback_delay_half_rate_line_unit.sv]
// Feedback echo delay with a half-rate delay line: top level.
// Uses fdhrl_pkg, fdhrl_ram and assert_macros.svh.
//
// Usage
//   req_*  : input samples, valid/ready. One beat per sample.
//   rsp_*  : output samples, valid/ready. One beat per input beat, in order.
//   csr_*  : register writes (delay, feedback, balance steps), taken on any
//            cycle with csr_write_en high; write only while the block is idle.
//   Throughput: one sample per cycle while rsp_ready is high. Each input
//   beat is registered in the product stage, then the output register.
//   The line memory takes one write and one read every other sample; the
//   read data is forwarded straight into the taps in the next cycle.
//   If rsp_ready is low the product stage and output register hold and
//   req_ready drops once both are full.
//   Reset: registers go to their defaults, taps and indices to zero. The line
//   memory is not swept: entries not yet written since reset read as zero,
//   tracked by the write index and a wrapped flag, so samples are taken from
//   the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module feedback_delay_half_rate_line_unit #(
   parameter int STEP_SAMPLES = fdhrl_pkg::STEP_SAMPLES_DEF,
   parameter int STEP_COUNT   = fdhrl_pkg::STEP_COUNT_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic signed [fdhrl_pkg::SAMPLE_W-1:0]    req_sample_in,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic signed      [fdhrl_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   input  wire logic                                     csr_write_en,
   input  wire logic        [fdhrl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic        [fdhrl_pkg::STEP_W-1:0]      csr_wdata
);

   import fdhrl_pkg::*;

   localparam int LINE_LEN = STEP_SAMPLES * STEP_COUNT;
   localparam int AW       = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int DW       = $clog2(STEP_SAMPLES * (2 ** STEP_W) + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(LINE_LEN - 1);
   localparam int PW       = SAMPLE_W + GAIN_W + 1;   // gain products
   localparam int LW       = PW + 1;                  // line input accumulator
   localparam int OW       = PW + 2;                  // output mix accumulator

   // config registers
   logic [STEP_W-1:0] delay_step_ff, delay_step_in;
   logic [STEP_W-1:0] fb_step_ff, fb_step_in;
   logic [STEP_W-1:0] bal_step_ff, bal_step_in;

   // line state
   logic [AW-1:0]              wr_idx_ff, wr_idx_in;
   logic                       wrapped_ff, wrapped_in;
   logic                       phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0] held_ff, held_in;
   logic signed [SAMPLE_W-1:0] older_ff, older_in;
   logic signed [SAMPLE_W-1:0] newer_ff, newer_in;
   logic signed [SAMPLE_W-1:0] line_out_ff, line_out_in;

   // read return tracking
   logic                       rd_pend_ff, rd_pend_in;
   logic                       rd_ok_ff, rd_ok_in;
   logic                       rd_fwd_ff, rd_fwd_in;
   logic signed [SAMPLE_W-1:0] wr_data_ff, wr_data_in;

   // product stage and output register
   logic                       prod_vld_ff, prod_vld_in;
   logic signed [PW-1:0]       dry_prod_ff, dry_prod_in;
   logic signed [PW-1:0]       wet_prod_ff, wet_prod_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   // derived gains and delay
   logic [GAIN_W-1:0] fb_prod, bal_prod, fb_gain, dry_lvl, wet_gain;
   logic [DW-1:0]     delay_prod;
   logic [AW-1:0]     delay_len;
   logic [AW:0]       rd_wrap;
   logic [AW-1:0]     rd_idx;

   logic                       out_free, prod_adv, accept, update;
   logic signed [SAMPLE_W-1:0] newer_eff, line_in, store_val;
   logic signed [PW-1:0]       fb_term;
   logic signed [LW-1:0]       line_acc;
   logic signed [SAMPLE_W:0]   store_sum, tap_sum;
   logic signed [OW-1:0]       mix_acc;
   logic [SAMPLE_W-1:0]        ram_rdata;
   logic                       ram_we, ram_re;

   always_comb begin
      fb_prod    = step_gain(fb_step_ff);
      bal_prod   = step_gain(bal_step_ff);
      fb_gain    = (fb_prod >= GAIN_UNITY) ? GAIN_UNITY : fb_prod;
      dry_lvl    = (bal_prod >= GAIN_UNITY) ? '0 : GAIN_UNITY - bal_prod;
      wet_gain   = GAIN_UNITY - dry_lvl;
      delay_prod = DW'(STEP_SAMPLES) * (DW'(delay_step_ff) + DW'(1));
      delay_len  = (delay_prod >= DW'(LINE_LEN)) ? LAST_IDX : delay_prod[AW-1:0];
      rd_wrap    = {1'b0, wr_idx_ff} + (AW + 1)'(LINE_LEN) - {1'b0, delay_len};
      if (wr_idx_ff >= delay_len) begin
         rd_idx = wr_idx_ff - delay_len;
      end else begin
         rd_idx = rd_wrap[AW-1:0];
      end
   end

   // handshake
   always_comb begin
      out_free  = !rsp_vld_ff || rsp_ready;
      prod_adv  = prod_vld_ff && out_free;
      req_ready = !prod_vld_ff || out_free;
      accept    = req_valid && req_ready;
      update    = accept && (wet_gain != '0);
   end

   // tap read lands in the cycle after the even-phase beat
   always_comb begin
      if (!rd_pend_ff) begin
         newer_eff = newer_ff;
      end else if (rd_fwd_ff) begin
         newer_eff = wr_data_ff;
      end else if (rd_ok_ff) begin
         newer_eff = $signed(ram_rdata);
      end else begin
         newer_eff = '0;
      end
   end

   // line input: (x*512 + fb*line_out) >> 10, kept to 16 bits
   always_comb begin
      fb_term   = $signed({1'b0, fb_gain}) * line_out_ff;
      line_acc  = $signed({req_sample_in, 9'b0}) + fb_term;
      line_in   = line_acc[MIX_SHIFT +: SAMPLE_W];
      store_sum = held_ff + line_in;
      store_val = store_sum[SAMPLE_W:1];
      tap_sum   = older_ff + newer_eff;
   end

   always_comb begin
      delay_step_in = delay_step_ff;
      fb_step_in    = fb_step_ff;
      bal_step_in   = bal_step_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DELAY:    delay_step_in = csr_wdata;
            CSR_FEEDBACK: fb_step_in    = csr_wdata;
            CSR_BALANCE:  bal_step_in   = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      wr_idx_in   = wr_idx_ff;
      wrapped_in  = wrapped_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      older_in    = older_ff;
      newer_in    = rd_pend_ff ? newer_eff : newer_ff;
      line_out_in = line_out_ff;
      rd_pend_in  = 1'b0;
      rd_ok_in    = rd_ok_ff;
      rd_fwd_in   = rd_fwd_ff;
      wr_data_in  = wr_data_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      if (update) begin
         if (!phase_ff) begin
            // even: write averaged pair, issue tap read, shift taps
            phase_in    = 1'b1;
            ram_we      = 1'b1;
            ram_re      = 1'b1;
            wr_data_in  = store_val;
            rd_pend_in  = 1'b1;
            rd_ok_in    = wrapped_ff || (rd_idx < wr_idx_ff);
            rd_fwd_in   = (rd_idx == wr_idx_ff);
            line_out_in = older_ff;
            older_in    = newer_eff;
            if (wr_idx_ff == LAST_IDX) begin
               wr_idx_in  = '0;
               wrapped_in = 1'b1;
            end else begin
               wr_idx_in = wr_idx_ff + AW'(1);
            end
         end else begin
            // odd: hold input, interpolate between taps
            phase_in    = 1'b0;
            held_in     = line_in;
            line_out_in = tap_sum[SAMPLE_W:1];
         end
      end
   end

   always_comb begin
      prod_vld_in = accept ? 1'b1 : (prod_adv ? 1'b0 : prod_vld_ff);
      dry_prod_in = dry_prod_ff;
      wet_prod_in = wet_prod_ff;
      if (accept) begin
         dry_prod_in = req_sample_in * $signed({1'b0, dry_lvl});
         wet_prod_in = line_out_in * $signed({1'b0, wet_gain});
      end
      mix_acc     = dry_prod_ff + $signed({wet_prod_ff, 1'b0});
      rsp_vld_in  = prod_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
      rsp_data_in = prod_adv ? mix_acc[MIX_SHIFT +: SAMPLE_W] : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_step_ff <= DELAY_STEP_RST;
         fb_step_ff    <= FEEDBACK_STEP_RST;
         bal_step_ff   <= BALANCE_STEP_RST;
         wr_idx_ff     <= '0;
         wrapped_ff    <= 1'b0;
         phase_ff      <= 1'b0;
         held_ff       <= '0;
         older_ff      <= '0;
         newer_ff      <= '0;
         line_out_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         delay_step_ff <= delay_step_in;
         fb_step_ff    <= fb_step_in;
         bal_step_ff   <= bal_step_in;
         wr_idx_ff     <= wr_idx_in;
         wrapped_ff    <= wrapped_in;
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         older_ff      <= older_in;
         newer_ff      <= newer_in;
         line_out_ff   <= line_out_in;
         rd_pend_ff    <= rd_pend_in;
         prod_vld_ff   <= prod_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      rd_ok_ff    <= rd_ok_in;
      rd_fwd_ff   <= rd_fwd_in;
      wr_data_ff  <= wr_data_in;
      dry_prod_ff <= dry_prod_in;
      wet_prod_ff <= wet_prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   fdhrl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (LINE_LEN),
      .AW    (AW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (store_val),
      .rd_en   (ram_re),
      .rd_addr (rd_idx),
      .rd_data (ram_rdata)
   );

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_sample_out = rsp_data_ff;

   `ASSERT_ALWAYS(a_idx_range, clock, reset, wr_idx_ff <= LAST_IDX, "write index past end of line")
   `ASSERT_ALWAYS(a_pend_phase, clock, reset, !rd_pend_ff || phase_ff, "tap read pending outside odd phase")
   `ASSERT_ALWAYS(a_fwd_pend, clock, reset, !rd_fwd_ff || !rd_pend_ff || (delay_len == '0), "self forward with nonzero delay")
   `ASSERT_NEXT(a_prod_hold, clock, reset, prod_vld_ff && !out_free, prod_vld_ff && $stable(dry_prod_ff), "product beat lost while stalled")
   `ASSERT_NEXT(a_bypass_state, clock, reset, accept && (wet_gain == '0), $stable(phase_ff) && $stable(wr_idx_ff), "line state moved on dry-only beat")

endmodule

`default_nettype wire

[rtl/fdhrl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fdhrl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4180,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[bench/feedback_delay_half_rate_line_unit_tb.sv]
// Self-checking bench for feedback_delay_half_rate_line_unit: random valid/ready
// traffic on both channels, checked against an in-bench echo predictor.
// Depends on fdhrl_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module feedback_delay_half_rate_line_unit_tb;
   import fdhrl_pkg::*;

   localparam int LINE_LEN       = STEP_SAMPLES_DEF * STEP_COUNT_DEF;
   localparam int RX_HOLD_CYCLES = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_DELAY;
   logic [STEP_W-1:0]          csr_wdata = '0;

   feedback_delay_half_rate_line_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state: knob copies and the half-rate line
   logic [STEP_W-1:0]          cfg_delay    = DELAY_STEP_RST;
   logic [STEP_W-1:0]          cfg_feedback = FEEDBACK_STEP_RST;
   logic [STEP_W-1:0]          cfg_balance  = BALANCE_STEP_RST;
   logic signed [SAMPLE_W-1:0] echo_mem [LINE_LEN];
   int                         wr_ptr     = 0;
   bit                         half_phase = 1'b0;
   logic signed [SAMPLE_W-1:0] held_in = '0;
   logic signed [SAMPLE_W-1:0] tap_old = '0;
   logic signed [SAMPLE_W-1:0] tap_new = '0;
   logic signed [SAMPLE_W-1:0] tap_out = '0;

   logic signed [SAMPLE_W-1:0] sample_backlog [$];
   logic signed [SAMPLE_W-1:0] echo_expected [$];
   logic signed [SAMPLE_W-1:0] want;

   int tx_idle_pct  = 23;
   int rx_idle_pct  = 50;
   int hold_request = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int errors       = 0;
   int beats_in     = 0;
   int beats_out    = 0;
   int phases_run   = 0;

   function automatic logic signed [SAMPLE_W-1:0] echo_predict(
      input logic signed [SAMPLE_W-1:0] x);
      longint dly, fb, dry, wet, acc;
      logic signed [SAMPLE_W-1:0] line_in;
      int rd;
      dly = longint'(STEP_SAMPLES_DEF) * (longint'(cfg_delay) + 1);
      if (dly >= LINE_LEN) dly = LINE_LEN - 1;
      fb = longint'(GAIN_STEP) * longint'(cfg_feedback);
      if (fb > longint'(GAIN_UNITY)) fb = longint'(GAIN_UNITY);
      dry = longint'(GAIN_UNITY) - longint'(GAIN_STEP) * longint'(cfg_balance);
      if (dry < 0) dry = 0;
      wet = longint'(GAIN_UNITY) - dry;
      // fully dry: straight through, line untouched
      if (wet == 0) return x;
      acc = longint'(x) * 512 + fb * longint'(tap_out);
      line_in = SAMPLE_W'(acc >>> MIX_SHIFT);
      if (half_phase) begin
         half_phase = 1'b0;
         held_in = line_in;
         tap_out = SAMPLE_W'((longint'(tap_old) + longint'(tap_new)) >>> 1);
      end else begin
         half_phase = 1'b1;
         echo_mem[wr_ptr] = SAMPLE_W'((longint'(held_in) + longint'(line_in)) >>> 1);
         rd = (wr_ptr >= dly) ? wr_ptr - int'(dly) : LINE_LEN + wr_ptr - int'(dly);
         wr_ptr = (wr_ptr == LINE_LEN - 1) ? 0 : wr_ptr + 1;
         tap_out = tap_old;
         tap_old = tap_new;
         tap_new = echo_mem[rd];
      end
      acc = longint'(x) * dry + 2 * longint'(tap_out) * wet;
      return SAMPLE_W'(acc >>> MIX_SHIFT);
   endfunction

   // sender: predicts on each accepted beat, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            echo_expected.push_back(echo_predict(req_sample_in));
            beats_in++;
         end
         if (!req_valid || req_ready) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_valid     <= 1'b1;
               req_sample_in <= sample_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each beat, random back-pressure plus long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (echo_expected.size() == 0) begin
               errors++;
               $display("%0t: sample_out expected none, got %0d", $time, rsp_sample_out);
            end else begin
               want = echo_expected.pop_front();
               if (rsp_sample_out !== want) begin
                  errors++;
                  $display("%0t: sample_out expected %0d, got %0d",
                           $time, want, rsp_sample_out);
               end
            end
         end
         if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = RX_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_DELAY:    cfg_delay    = val;
         CSR_FEEDBACK: cfg_feedback = val;
         CSR_BALANCE:  cfg_balance  = val;
         default:      ;
      endcase
   endtask

   // queue random samples, then wait until the block has drained
   task automatic run_phase(input int n, input int tx_pct, input int rx_pct,
                            input bit stall_rx);
      int k;
      logic signed [SAMPLE_W-1:0] s;
      @(negedge clock);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0:             s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3, 4, 5: s = SAMPLE_W'($urandom);
            default:       s = SAMPLE_W'($urandom_range(2047)) - 16'sd1024;
         endcase
         sample_backlog.push_back(s);
      end
      if (stall_rx) hold_request++;
      phases_run++;
      while (sample_backlog.size() != 0 || req_valid || echo_expected.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < LINE_LEN; i++) echo_mem[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset knob values, no writes yet
      @(negedge clock);
      sample_backlog.push_back(16'sd0);
      sample_backlog.push_back(16'sh7fff);
      sample_backlog.push_back(16'sh8000);
      sample_backlog.push_back(-16'sd1);
      sample_backlog.push_back(16'sd1);
      sample_backlog.push_back(16'sh5555);
      sample_backlog.push_back(16'shaaaa);
      run_phase(100, 23, 50, 1'b0);

      // shortest delay, heavy feedback, fully wet: wraps on both sums
      csr_write(CSR_DELAY, 5'd0);
      csr_write(CSR_FEEDBACK, 5'd18);
      csr_write(CSR_BALANCE, 5'd18);
      @(negedge clock);
      repeat (4) sample_backlog.push_back(16'sh7fff);
      repeat (2) sample_backlog.push_back(16'sh8000);
      run_phase(250, 23, 50, 1'b1);

      // feedback step past the cap
      csr_write(CSR_DELAY, 5'd1);
      csr_write(CSR_FEEDBACK, 5'd31);
      csr_write(CSR_BALANCE, 5'd5);
      run_phase(200, 50, 23, 1'b0);

      // fully dry passes straight through; unused index must be ignored
      csr_write(CSR_BALANCE, 5'd0);
      csr_write(CSR_UNUSED, 5'd31);
      @(negedge clock);
      sample_backlog.push_back(16'sh8000);
      sample_backlog.push_back(16'sh7fff);
      sample_backlog.push_back(16'sd0);
      sample_backlog.push_back(16'sd12345);
      run_phase(50, 50, 23, 1'b0);

      // delay past the line length clamps, no feedback, balance past the floor
      csr_write(CSR_DELAY, 5'd31);
      csr_write(CSR_FEEDBACK, 5'd0);
      csr_write(CSR_BALANCE, 5'd31);
      @(negedge clock);
      sample_backlog.push_back(16'sh7fff);
      sample_backlog.push_back(16'sh8000);
      sample_backlog.push_back(-16'sd1);
      run_phase(100, 0, 0, 1'b0);

      csr_write(CSR_DELAY, 5'd0);
      csr_write(CSR_FEEDBACK, 5'd12);
      csr_write(CSR_BALANCE, 5'd12);
      run_phase(200, 0, 0, 1'b1);

      repeat (8) @(posedge clock);
      if (echo_expected.size() != 0) begin
         errors++;
         $display("%0t: %0d samples never came out", $time, echo_expected.size());
      end
      $display("run: %0d beats in, %0d out, %0d knob settings", beats_in, beats_out,
               phases_run);
      $display("incl. dry passthrough, delay clamp, gain caps and long back-pressure");
      if (errors == 0) begin
         $display("feedback_delay_half_rate_line_unit: match");
      end else begin
         $display("feedback_delay_half_rate_line_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout at %0t", $time);
      $display("feedback_delay_half_rate_line_unit: mismatch");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/fdhrl_pkg.sv
rtl/fdhrl_ram.sv
rtl/feedback_delay_half_rate_line_unit.sv
bench/feedback_delay_half_rate_line_unit_tb.sv
